### sv/sdc_pkg.sv
// Shared constants, codes and types for the SLIP deframer and classifier.
// No dependencies; compiled first.
`default_nettype none

package sdc_pkg;

  // Frame length limits and widths
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int LEN_W           = 12;
  localparam logic [LEN_W-1:0] CFG_RESET_LEN = 12'd2048;

  // Result queue sizing: room for two results per item plus slack
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // SLIP framing codes
  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  // Characters used by the classifier
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_BANG  = 8'h21;
  localparam logic [7:0] CHR_QUERY = 8'h3F;
  localparam logic [7:0] CHR_TILDE = 8'h7E;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  // Frame classes
  localparam logic [2:0] CLS_COMMAND = 3'd0;
  localparam logic [2:0] CLS_QUERY   = 3'd1;
  localparam logic [2:0] CLS_DEBUG   = 3'd2;
  localparam logic [2:0] CLS_TEXT    = 3'd3;
  localparam logic [2:0] CLS_PACKET  = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [2:0]       frame_class;
    logic [LEN_W-1:0] frame_length;
  } sdc_result_t;

  // Up to two results per input beat; r0 goes out first
  typedef struct packed {
    logic        push0;
    logic        push1;
    sdc_result_t r0;
    sdc_result_t r1;
  } sdc_push_t;

endpackage

`default_nettype wire

### sv/sdc_if.sv
// Channel interfaces: raw byte input, result output, config write.
// Depends on sdc_pkg.
`default_nettype none

interface sdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdc_result_if import sdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       data_byte;
  logic [2:0]       frame_class;
  logic [LEN_W-1:0] frame_length;
  modport source (output valid, output kind, output data_byte, output frame_class,
                  output frame_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_class,
                  input frame_length, output ready);
endinterface

interface sdc_cfg_if import sdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] max_frame_length;
  modport source (output valid, output max_frame_length, input ready);
  modport sink   (input valid, input max_frame_length, output ready);
endinterface

`default_nettype wire

### sv/sdc_decode.sv
// SLIP unescape, length check and frame classification; holds frame state.
// Depends on sdc_pkg. Produces up to two results per accepted beat.
`default_nettype none

module sdc_decode import sdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic [LEN_W-1:0] max_frame_length,
  output sdc_push_t        push
);

  logic             escape_pending, escape_pending_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       first_payload_byte, first_payload_byte_next;
  logic             printable_so_far, printable_so_far_next;

  logic [LEN_W-1:0] limit;
  logic             drop;
  logic [LEN_W-1:0] cnt0;
  logic [7:0]       first0;
  logic             print0;
  logic [7:0]       c;
  logic             emit_data, emit_end;
  logic [2:0]       cls;
  sdc_result_t      drop_res, main_res;

  function automatic logic byte_is_texty(input logic [7:0] b);
    return (b == CHR_NUL) || (b == CHR_CR) || (b == CHR_LF) || (b == CHR_TAB) ||
           ((b >= CHR_SPACE) && (b <= CHR_TILDE));
  endfunction

  // Effective limit: zero reads as one, clamp to the build maximum
  always_comb begin
    if (max_frame_length == '0) begin
      limit = LEN_W'(1);
    end else if (int'(max_frame_length) > MAX_FRAME_BYTES) begin
      limit = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      limit = max_frame_length;
    end
  end

  // Drop check comes first and restarts the frame, escape state kept
  assign drop   = byte_count >= limit;
  assign cnt0   = drop ? '0 : byte_count;
  assign first0 = drop ? '0 : first_payload_byte;
  assign print0 = drop ? 1'b1 : printable_so_far;

  // Frame class from first byte and text flag
  always_comb begin
    priority if (first0 == CHR_BANG) begin
      cls = CLS_COMMAND;
    end else if (first0 == CHR_QUERY) begin
      cls = CLS_QUERY;
    end else if (first0 == CHR_CR) begin
      cls = CLS_DEBUG;
    end else if (print0) begin
      cls = CLS_TEXT;
    end else begin
      cls = CLS_PACKET;
    end
  end

  // Unescape and next-state logic
  always_comb begin
    escape_pending_next     = escape_pending;
    byte_count_next         = cnt0;
    first_payload_byte_next = first0;
    printable_so_far_next   = print0;
    c                       = rx_byte;
    emit_data               = 1'b0;
    emit_end                = 1'b0;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      emit_data           = 1'b1;
      if (rx_byte == BYTE_ESC_END) begin
        c = BYTE_END;
      end else if (rx_byte == BYTE_ESC_ESC) begin
        c = BYTE_ESC;
      end
    end else if (rx_byte == BYTE_END) begin
      if (cnt0 != '0) begin
        emit_end                = 1'b1;
        byte_count_next         = '0;
        first_payload_byte_next = '0;
        printable_so_far_next   = 1'b1;
      end
    end else if (rx_byte == BYTE_ESC) begin
      escape_pending_next = 1'b1;
    end else begin
      emit_data = 1'b1;
    end
    if (emit_data) begin
      if (cnt0 == '0) begin
        first_payload_byte_next = c;
      end else if (!byte_is_texty(c)) begin
        printable_so_far_next = 1'b0;
      end
      byte_count_next = cnt0 + LEN_W'(1);
    end
  end

  // Result assembly: drop notice goes ahead of the byte's own result
  always_comb begin
    drop_res = '{kind: KIND_DROP, data_byte: '0, frame_class: '0, frame_length: byte_count};
    if (emit_end) begin
      main_res = '{kind: KIND_END, data_byte: '0, frame_class: cls, frame_length: cnt0};
    end else begin
      main_res = '{kind: KIND_DATA, data_byte: c, frame_class: '0, frame_length: '0};
    end
    push.push0 = fire && (drop || emit_data || emit_end);
    push.push1 = fire && drop && (emit_data || emit_end);
    push.r0    = drop ? drop_res : main_res;
    push.r1    = main_res;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending     <= 1'b0;
      byte_count         <= '0;
      first_payload_byte <= '0;
      printable_so_far   <= 1'b1;
    end else if (fire) begin
      escape_pending     <= escape_pending_next;
      byte_count         <= byte_count_next;
      first_payload_byte <= first_payload_byte_next;
      printable_so_far   <= printable_so_far_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(byte_count) <= MAX_FRAME_BYTES)
    else $error("byte count above frame maximum");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (push.push0 && push.r0.kind == KIND_DROP))
    else $error("second result without leading drop notice");

  a_drop_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && drop && !emit_data) |=> byte_count == '0)
    else $error("frame count not restarted after drop");

endmodule

`default_nettype wire

### sv/sdc_result_queue.sv
// Small result queue: takes up to two results a cycle, emits one per beat.
// Depends on sdc_pkg and sdc_if.
`default_nettype none

module sdc_result_queue import sdc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  sdc_push_t           push,
  output logic                room,
  sdc_result_if.source        result
);

  sdc_result_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_push;
  logic             pop;
  sdc_result_t      head;

  // Room for a worst-case item of two results
  assign room   = count <= CNT_W'(QUEUE_DEPTH - 2);
  assign n_push = CNT_W'(push.push0) + CNT_W'(push.push1);
  assign pop    = result.valid && result.ready;

  // Head of queue drives the output
  assign head                = slots[rd_ptr];
  assign result.valid        = count != '0;
  assign result.kind         = head.kind;
  assign result.data_byte    = head.data_byte;
  assign result.frame_class  = head.frame_class;
  assign result.frame_length = head.frame_length;

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.push0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.push1) begin
      slots[PTR_W'(wr_ptr + PTR_W'(1))] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + n_push - CNT_W'(pop);
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= QUEUE_DEPTH)
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> room)
    else $error("push into full result queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.push0) |=> count == $past(count) - CNT_W'(1))
    else $error("count did not drop on pop");

endmodule

`default_nettype wire

### sv/slip_deframer_classifier.sv
// SLIP deframer and frame classifier, top level.
// Depends on sdc_pkg, sdc_if, sdc_decode and sdc_result_queue.
//
//   channel  dir  payload                                        beat when
//   rx       in   rx_byte[7:0]                                   valid & ready
//   result   out  kind, data_byte, frame_class, frame_length     valid & ready
//   cfg      in   max_frame_length[11:0]                         valid & ready
//
// One input beat per cycle while the queue has room; each byte is decoded in the cycle
// it is taken and its results enter a four-entry result queue, first result visible the
// next cycle. A byte that causes a drop notice plus a data or frame-end result needs two
// output beats; the queue absorbs that, so input stalls only when it is over half full.
// Synchronous reset clears frame state, the queue and sets the limit to 2048.
// cfg is always ready.
`default_nettype none

module slip_deframer_classifier import sdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sdc_byte_if.sink     rx,
  sdc_result_if.source result,
  sdc_cfg_if.sink      cfg
);

  logic [LEN_W-1:0] max_frame_length;
  logic             room;
  logic             fire;
  sdc_push_t        push;

  // Limit register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= CFG_RESET_LEN;
    end else if (cfg.valid && cfg.ready) begin
      max_frame_length <= cfg.max_frame_length;
    end
  end

  // Input handshake
  assign rx.ready = room;
  assign fire     = rx.valid && room;

  sdc_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .rx_byte          (rx.rx_byte),
    .max_frame_length (max_frame_length),
    .push             (push)
  );

  sdc_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule

`default_nettype wire
